// File: rtl/tun_pkg.sv
// triangle unit normal: shared constants
// no dependencies
`timescale 1ns / 1ps

package tun_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned NORMAL_W = 16;
  // register stages from an accepted beat to its result strobe, besides the per-bit lane stages
  localparam int unsigned LAT_BASE = 8;

endpackage

// File: rtl/tun_cross.sv
// triangle unit normal: edge vectors and exact cross product
// three register stages; magnitude and sign per component
`timescale 1ns / 1ps

module tun_cross #(
  parameter int unsigned CW = 24,
  parameter int unsigned MW = 2 * (CW + 1) + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] a_x_i,
  input  logic signed [CW-1:0] a_y_i,
  input  logic signed [CW-1:0] a_z_i,
  input  logic signed [CW-1:0] b_x_i,
  input  logic signed [CW-1:0] b_y_i,
  input  logic signed [CW-1:0] b_z_i,
  input  logic signed [CW-1:0] c_x_i,
  input  logic signed [CW-1:0] c_y_i,
  input  logic signed [CW-1:0] c_z_i,
  output logic                 valid_o,
  output logic [MW-1:0]        mag_o [3],
  output logic                 neg_o [3]
);

  localparam int unsigned EW = CW + 1;
  localparam int unsigned PW = 2 * EW;

  logic signed [EW-1:0] u_q [3];
  logic signed [EW-1:0] w_q [3];
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic [MW-1:0]        mag_q [3];
  logic                 neg_q [3];
  logic signed [MW-1:0] c_w [3];
  logic [2:0]           vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // edges from the first vertex
  always_ff @(posedge clk_i) begin
    u_q[0] <= {b_x_i[CW-1], b_x_i} - {a_x_i[CW-1], a_x_i};
    u_q[1] <= {b_y_i[CW-1], b_y_i} - {a_y_i[CW-1], a_y_i};
    u_q[2] <= {b_z_i[CW-1], b_z_i} - {a_z_i[CW-1], a_z_i};
    w_q[0] <= {c_x_i[CW-1], c_x_i} - {a_x_i[CW-1], a_x_i};
    w_q[1] <= {c_y_i[CW-1], c_y_i} - {a_y_i[CW-1], a_y_i};
    w_q[2] <= {c_z_i[CW-1], c_z_i} - {a_z_i[CW-1], a_z_i};
  end

  always_ff @(posedge clk_i) begin
    pa_q[0] <= u_q[1] * w_q[2];
    pb_q[0] <= u_q[2] * w_q[1];
    pa_q[1] <= u_q[2] * w_q[0];
    pb_q[1] <= u_q[0] * w_q[2];
    pa_q[2] <= u_q[0] * w_q[1];
    pb_q[2] <= u_q[1] * w_q[0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_w[i] = $signed({pa_q[i][PW-1], pa_q[i]}) - $signed({pb_q[i][PW-1], pb_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mag_q[i] <= c_w[i][MW-1] ? -c_w[i] : c_w[i];
      neg_q[i] <= c_w[i][MW-1];
    end
  end

  assign valid_o = vld_q[2];
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule

// File: rtl/tun_square.sv
// triangle unit normal: squares of the cross components and their sum
// split multipliers over two stages, sum in a third
`timescale 1ns / 1ps

module tun_square #(
  parameter int unsigned MW = 51
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [MW-1:0]     mag_i [3],
  input  logic              neg_i [3],
  output logic              valid_o,
  output logic [2*MW-1:0]   sq_o [3],
  output logic [2*MW+1:0]   s_o,
  output logic              neg_o [3]
);

  localparam int unsigned HW = (MW + 1) / 2;
  localparam int unsigned LW = MW - HW;
  localparam int unsigned SW = 2 * MW;
  localparam int unsigned TW = SW + 2;

  logic [2*HW-1:0]  hh_q [3];
  logic [HW+LW-1:0] hl_q [3];
  logic [2*LW-1:0]  ll_q [3];
  logic [SW-1:0]    sq_q [3];
  logic [SW-1:0]    sqd_q [3];
  logic [TW-1:0]    s_q;
  logic             n1_q [3];
  logic             n2_q [3];
  logic             n3_q [3];
  logic [2:0]       vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      hh_q[i] <= mag_i[i][MW-1:LW] * mag_i[i][MW-1:LW];
      hl_q[i] <= mag_i[i][MW-1:LW] * mag_i[i][LW-1:0];
      ll_q[i] <= mag_i[i][LW-1:0] * mag_i[i][LW-1:0];
      n1_q[i] <= neg_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= (SW'(hh_q[i]) << (2 * LW)) + (SW'(hl_q[i]) << (LW + 1)) + SW'(ll_q[i]);
      n2_q[i] <= n1_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= TW'(sq_q[0]) + TW'(sq_q[1]) + TW'(sq_q[2]);
    for (int i = 0; i < 3; i++) begin
      sqd_q[i] <= sq_q[i];
      n3_q[i]  <= n2_q[i];
    end
  end

  assign valid_o = vld_q[2];
  assign sq_o    = sqd_q;
  assign s_o     = s_q;
  assign neg_o   = n3_q;

endmodule

// File: rtl/tun_lane.sv
// triangle unit normal: one normal component, one result bit per stage
// exact round to nearest of mag / sqrt(s) by shift-and-add residue tracking
`timescale 1ns / 1ps

module tun_lane #(
  parameter int unsigned MW = 51,
  parameter int unsigned NW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [2*MW-1:0]      sq_i,
  input  logic [2*MW+1:0]      s_i,
  input  logic                 neg_i,
  output logic                 valid_o,
  output logic signed [NW-1:0] norm_o,
  output logic                 deg_o
);

  localparam int unsigned F    = NW - 1;
  localparam int unsigned TW   = 2 * MW + 2;
  localparam int unsigned AW   = 2 * MW + 2 * F + 5;
  localparam int unsigned NSTG = F + 1;

  // residue r = 4 sq 2^(2F) - k^2 s and p = k s, with k = 2q - 1
  logic [AW-1:0] r_q [NSTG+1];
  logic [AW-1:0] p_q [NSTG+1];
  logic [TW-1:0] s_q [NSTG+1];
  logic [NW-1:0] q_q [NSTG+1];
  logic          neg_q [NSTG+1];
  logic          deg_q [NSTG+1];
  logic          vld_q [NSTG+1];

  logic [AW-1:0] s_w;
  logic [NW-1:0] mag_w;
  logic [NW-1:0] out_d;
  logic [NW-1:0] norm_q;
  logic          deg_out_q;
  logic          vld_out_q;

  assign s_w = AW'(s_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]   <= (AW'(sq_i) << (2 * F + 2)) - s_w;
    p_q[0]   <= '0 - s_w;
    s_q[0]   <= s_i;
    q_q[0]   <= '0;
    neg_q[0] <= neg_i;
    deg_q[0] <= (s_i == '0);
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_bit
    localparam int unsigned B = F - g;
    logic [AW-1:0] d_w;
    logic [AW-1:0] t_w;
    logic          ok_w;

    always_comb begin
      d_w  = (p_q[g] << (B + 2)) + (AW'(s_q[g]) << (2 * B + 2));
      t_w  = r_q[g] - d_w;
      ok_w = !q_q[g][F] && !t_w[AW-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[g+1]   <= ok_w ? t_w : r_q[g];
      p_q[g+1]   <= ok_w ? p_q[g] + (AW'(s_q[g]) << (B + 1)) : p_q[g];
      q_q[g+1]   <= ok_w ? (q_q[g] | (NW'(1) << B)) : q_q[g];
      s_q[g+1]   <= s_q[g];
      neg_q[g+1] <= neg_q[g];
      deg_q[g+1] <= deg_q[g];
    end
  end

  // plus one saturates, minus one stays representable
  always_comb begin
    mag_w = q_q[NSTG];
    if (!neg_q[NSTG] && mag_w[F]) begin
      mag_w = {1'b0, {F{1'b1}}};
    end
    out_d = neg_q[NSTG] ? ('0 - mag_w) : mag_w;
    if (deg_q[NSTG]) begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q    <= out_d;
    deg_out_q <= deg_q[NSTG];
  end

  assign valid_o = vld_out_q;
  assign norm_o  = $signed(norm_q);
  assign deg_o   = deg_out_q;

endmodule

// File: rtl/triangle_unit_normal_top.sv
// triangle unit normal: top level
// uses tun_pkg, tun_cross, tun_square and tun_lane
`timescale 1ns / 1ps

// Takes one triangle per clock and returns its unit face normal in signed
// Q1.15 (exact quotient rounded to nearest, +1.0 saturated). busy is always
// low: a beat is accepted whenever start is high. The result appears on the
// output ports for one cycle with valid_o high, after passing three stages for
// the edges and cross product, three for the squares and their sum, then one
// stage per result bit in each component lane plus setup and output
// registers. Results come in the order of the beats and cannot be held off
// by the receiver.
// A zero cross product gives a zero normal with degenerate_o set.

module triangle_unit_normal_top #(
  parameter int unsigned COORD_WIDTH  = tun_pkg::COORD_W,
  parameter int unsigned NORMAL_WIDTH = tun_pkg::NORMAL_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  a_x_i,
  input  logic signed [COORD_WIDTH-1:0]  a_y_i,
  input  logic signed [COORD_WIDTH-1:0]  a_z_i,
  input  logic signed [COORD_WIDTH-1:0]  b_x_i,
  input  logic signed [COORD_WIDTH-1:0]  b_y_i,
  input  logic signed [COORD_WIDTH-1:0]  b_z_i,
  input  logic signed [COORD_WIDTH-1:0]  c_x_i,
  input  logic signed [COORD_WIDTH-1:0]  c_y_i,
  input  logic signed [COORD_WIDTH-1:0]  c_z_i,
  output logic                           valid_o,
  output logic signed [NORMAL_WIDTH-1:0] norm_x_o,
  output logic signed [NORMAL_WIDTH-1:0] norm_y_o,
  output logic signed [NORMAL_WIDTH-1:0] norm_z_o,
  output logic                           degenerate_o
);

  localparam int unsigned MW = 2 * (COORD_WIDTH + 1) + 1;

  logic                  cr_vld;
  logic [MW-1:0]         cr_mag [3];
  logic                  cr_neg [3];
  logic                  sq_vld;
  logic [2*MW-1:0]       sq_val [3];
  logic [2*MW+1:0]       sq_sum;
  logic                  sq_neg [3];
  logic                  ln_vld [3];
  logic                  ln_deg [3];
  logic signed [NORMAL_WIDTH-1:0] ln_norm [3];

  assign busy = 1'b0;

  tun_cross #(
    .CW (COORD_WIDTH),
    .MW (MW)
  ) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .a_x_i   (a_x_i),
    .a_y_i   (a_y_i),
    .a_z_i   (a_z_i),
    .b_x_i   (b_x_i),
    .b_y_i   (b_y_i),
    .b_z_i   (b_z_i),
    .c_x_i   (c_x_i),
    .c_y_i   (c_y_i),
    .c_z_i   (c_z_i),
    .valid_o (cr_vld),
    .mag_o   (cr_mag),
    .neg_o   (cr_neg)
  );

  tun_square #(
    .MW (MW)
  ) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cr_vld),
    .mag_i   (cr_mag),
    .neg_i   (cr_neg),
    .valid_o (sq_vld),
    .sq_o    (sq_val),
    .s_o     (sq_sum),
    .neg_o   (sq_neg)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tun_lane #(
      .MW (MW),
      .NW (NORMAL_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld),
      .sq_i    (sq_val[i]),
      .s_i     (sq_sum),
      .neg_i   (sq_neg[i]),
      .valid_o (ln_vld[i]),
      .norm_o  (ln_norm[i]),
      .deg_o   (ln_deg[i])
    );
  end

  assign valid_o      = ln_vld[0] & ln_vld[1] & ln_vld[2];
  assign degenerate_o = ln_deg[0] & ln_deg[1] & ln_deg[2];
  assign norm_x_o     = ln_norm[0];
  assign norm_y_o     = ln_norm[1];
  assign norm_z_o     = ln_norm[2];

endmodule

// File: rtl/tun_chk.sv
// triangle unit normal: port-level checks over time
// uses tun_pkg; bound to triangle_unit_normal_top
`timescale 1ns / 1ps

module tun_chk #(
  parameter int unsigned NORMAL_WIDTH = tun_pkg::NORMAL_W
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    valid_o,
  input logic [NORMAL_WIDTH-1:0] norm_x_o,
  input logic [NORMAL_WIDTH-1:0] norm_y_o,
  input logic [NORMAL_WIDTH-1:0] norm_z_o,
  input logic                    degenerate_o
);

  localparam int unsigned LAT = NORMAL_WIDTH + tun_pkg::LAT_BASE;

  // never stalls the sender
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // every result comes from an earlier accepted beat
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, LAT))
    else $error("result without matching beat");

  // every beat produces its result
  a_beat_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT valid_o)
    else $error("beat lost");

  // degenerate gives a zero vector
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && degenerate_o) |-> (norm_x_o == '0 && norm_y_o == '0 && norm_z_o == '0))
    else $error("degenerate normal not zero");

  // a real normal has a nonzero component
  a_nondeg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !degenerate_o) |-> (norm_x_o != '0 || norm_y_o != '0 || norm_z_o != '0))
    else $error("nondegenerate normal is zero");

endmodule

bind triangle_unit_normal_top tun_chk #(
  .NORMAL_WIDTH (NORMAL_WIDTH)
) u_tun_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .norm_x_o     (norm_x_o),
  .norm_y_o     (norm_y_o),
  .norm_z_o     (norm_z_o),
  .degenerate_o (degenerate_o)
);

// File: verif/testbench.sv
// triangle unit normal: self-checking testbench with its own normal predictor
// depends on tun_pkg and triangle_unit_normal_top
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [tun_pkg::COORD_W-1:0] coord_t;
  typedef logic signed [tun_pkg::NORMAL_W-1:0] comp_t;

  typedef struct {
    coord_t v [9];
    int     gap;
    bit     hold;
  } tri_t;

  typedef struct {
    comp_t nx;
    comp_t ny;
    comp_t nz;
    logic  degen;
  } normal_t;

  localparam int unsigned SETTLE = tun_pkg::LAT_BASE + tun_pkg::NORMAL_W + 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  coord_t a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i;
  logic   valid_o;
  comp_t  norm_x_o, norm_y_o, norm_z_o;
  logic   degenerate_o;

  tri_t    triangles [$];
  normal_t normals_due [$];
  int      n_triangles;
  int      n_taken;
  int      n_errors;
  int      wait_cnt;
  bit      armed;
  logic    took;
  int      cycle_cnt;

  triangle_unit_normal_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .a_x_i        (a_x_i),
    .a_y_i        (a_y_i),
    .a_z_i        (a_z_i),
    .b_x_i        (b_x_i),
    .b_y_i        (b_y_i),
    .b_z_i        (b_z_i),
    .c_x_i        (c_x_i),
    .c_y_i        (c_y_i),
    .c_z_i        (c_z_i),
    .valid_o      (valid_o),
    .norm_x_o     (norm_x_o),
    .norm_y_o     (norm_y_o),
    .norm_z_o     (norm_z_o),
    .degenerate_o (degenerate_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // exact quotient n / |n| in Q1.15, rounded to nearest, ties away from zero
  function automatic comp_t unit_comp(longint n, logic [159:0] sum_sq);
    logic [159:0] mag;
    logic [159:0] rhs;
    logic [159:0] t;
    logic [159:0] k;
    logic [159:0] r;
    bit           neg;
    neg = n < 0;
    mag = neg ? 160'(-n) : 160'(n);
    rhs = (mag * mag) << (2 * (tun_pkg::NORMAL_W - 1) + 2);
    r = '0;
    for (int b = tun_pkg::NORMAL_W - 1; b >= 0; b--) begin
      t = r | (160'(1) << b);
      k = 2 * t - 1;
      if (t <= (160'(1) << (tun_pkg::NORMAL_W - 1)) && k * k * sum_sq <= rhs) r = t;
    end
    if (!neg && r > (160'(1) << (tun_pkg::NORMAL_W - 1)) - 1) begin
      r = (160'(1) << (tun_pkg::NORMAL_W - 1)) - 1;
    end
    return neg ? comp_t'(-r) : comp_t'(r);
  endfunction

  function automatic normal_t face_normal(tri_t tr);
    longint  ux, uy, uz, wx, wy, wz;
    longint  n [3];
    logic [159:0] sum_sq;
    normal_t res;
    ux = longint'(tr.v[3]) - longint'(tr.v[0]);
    uy = longint'(tr.v[4]) - longint'(tr.v[1]);
    uz = longint'(tr.v[5]) - longint'(tr.v[2]);
    wx = longint'(tr.v[6]) - longint'(tr.v[0]);
    wy = longint'(tr.v[7]) - longint'(tr.v[1]);
    wz = longint'(tr.v[8]) - longint'(tr.v[2]);
    n[0] = uy * wz - uz * wy;
    n[1] = uz * wx - ux * wz;
    n[2] = ux * wy - uy * wx;
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      sum_sq += 160'(n[i] < 0 ? -n[i] : n[i]) * 160'(n[i] < 0 ? -n[i] : n[i]);
    end
    if (sum_sq == 0) begin
      res = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    end else begin
      res.nx = unit_comp(n[0], sum_sq);
      res.ny = unit_comp(n[1], sum_sq);
      res.nz = unit_comp(n[2], sum_sq);
      res.degen = 1'b0;
    end
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("error: %s got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  task automatic add_tri(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                         coord_t bz, coord_t cx, coord_t cy, coord_t cz);
    tri_t tr;
    tr.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    tr.gap = ((n_triangles / 64) % 2) ? 0 : $urandom_range(0, 12);
    tr.hold = (n_triangles == 300 || n_triangles == 700);
    triangles.insert(triangles.size(), tr);
    n_triangles++;
  endtask

  function automatic coord_t rnd_coord(int unsigned span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  // accept beats and take result strobes at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (start && !busy) begin
        tri_t tr;
        tr.v = '{a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i};
        normals_due.insert(normals_due.size(), face_normal(tr));
        n_taken++;
      end
      if (valid_o) begin
        if (normals_due.size() == 0) begin
          report("result beat with nothing pending", 1, 0);
        end else begin
          normal_t want;
          want = normals_due.pop_front();
          if (norm_x_o !== want.nx) report("norm_x", norm_x_o, want.nx);
          if (norm_y_o !== want.ny) report("norm_y", norm_y_o, want.ny);
          if (norm_z_o !== want.nz) report("norm_z", norm_z_o, want.nz);
          if (degenerate_o !== want.degen) report("degenerate", degenerate_o, want.degen);
        end
      end
    end
  end

  // present triangles at the falling edge
  always @(negedge clk_i) begin
    logic go;
    tri_t tr;
    go = 1'b0;
    if (rst_ni) begin
      if (start && !took) begin
        go = 1'b1;
      end else begin
        if (!armed && triangles.size() != 0) begin
          wait_cnt = triangles[0].gap;
          armed = 1'b1;
        end
        if (armed) begin
          if (wait_cnt > 0) begin
            wait_cnt--;
          end else if (!triangles[0].hold || normals_due.size() == 0) begin
            tr = triangles.pop_front();
            {a_x_i, a_y_i, a_z_i} <= {tr.v[0], tr.v[1], tr.v[2]};
            {b_x_i, b_y_i, b_z_i} <= {tr.v[3], tr.v[4], tr.v[5]};
            {c_x_i, c_y_i, c_z_i} <= {tr.v[6], tr.v[7], tr.v[8]};
            armed = 1'b0;
            go = 1'b1;
          end
        end
      end
    end
    start <= go;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("triangle_unit_normal_top: mismatch");
      $finish;
    end
  end

  initial begin
    coord_t mx, mn;
    coord_t p [3];
    coord_t d [3];
    int     sel;
    int     span;
    mx = {1'b0, {(tun_pkg::COORD_W-1){1'b1}}};
    mn = {1'b1, {(tun_pkg::COORD_W-1){1'b0}}};
    n_triangles = 0;
    n_taken = 0;
    n_errors = 0;
    cycle_cnt = 0;
    armed = 1'b0;
    wait_cnt = 0;
    start = 1'b0;
    {a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i} = '0;
    rst_ni = 1'b0;

    // degenerate: all points equal, collinear, zero
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx);
    add_tri(0, 0, 0, 1, 2, 3, 2, 4, 6);
    add_tri(mn, mn, mn, mx, mx, mx, 0, 0, 0);
    // axis-aligned normals: plus and minus one on each component
    add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_tri(0, 0, 0, 0, 1, 0, 1, 0, 0);
    add_tri(0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_tri(0, 0, 0, 0, 0, 1, 0, 1, 0);
    add_tri(0, 0, 0, 0, 0, 1, 1, 0, 0);
    add_tri(0, 0, 0, 1, 0, 0, 0, 0, 1);
    // field extremes
    add_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn);
    add_tri(mx, mx, mx, mn, mx, mx, mx, mx, mn);
    add_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx);
    add_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn);
    add_tri(mn, mn, mn, mx, mx, mn, mx, mn, mx);
    add_tri(-1, -1, -1, mx, 0, 0, 0, mn, 0);
    // diagonal normal, equal components
    add_tri(1, 0, 0, 0, 1, 0, 0, 0, 1);
    add_tri(0, 0, 1, 0, 1, 0, 1, 0, 0);
    add_tri(mx, 0, 0, 0, mx, 0, 0, 0, mx);

    while (n_triangles < 1070) begin
      sel = $urandom_range(0, 9);
      span = (sel < 3) ? 0 : (sel < 6) ? $urandom_range(1, 64) : $urandom_range(1, 1 << 20);
      for (int i = 0; i < 3; i++) begin
        p[i] = rnd_coord(span);
        d[i] = rnd_coord(span == 0 ? 1 << 10 : span);
      end
      if (sel == 9) begin
        // collinear third vertex
        add_tri(p[0], p[1], p[2], p[0] + d[0], p[1] + d[1], p[2] + d[2],
                coord_t'(p[0] - 2 * d[0]), coord_t'(p[1] - 2 * d[1]),
                coord_t'(p[2] - 2 * d[2]));
      end else if (sel == 8) begin
        // triangle in an axis plane
        add_tri(p[0], p[1], p[2], p[0] + d[0], p[1] + d[1], p[2],
                rnd_coord(span), rnd_coord(span), p[2]);
      end else begin
        add_tri(p[0], p[1], p[2], rnd_coord(span), rnd_coord(span), rnd_coord(span),
                rnd_coord(span), rnd_coord(span), rnd_coord(span));
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (n_taken == n_triangles && normals_due.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("triangle_unit_normal_top: match");
    end else begin
      $display("triangle_unit_normal_top: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tun_pkg.sv
rtl/tun_cross.sv
rtl/tun_square.sv
rtl/tun_lane.sv
rtl/triangle_unit_normal_top.sv
rtl/tun_chk.sv
verif/testbench.sv
